// File: rtl/julia_escape_time_macros.svh
// assertion macros for the julia escape-time block
// no dependencies; taken in by files that carry concurrent checks
`ifndef JULIA_ESCAPE_TIME_MACROS_SVH
`define JULIA_ESCAPE_TIME_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define JET_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property must never hold outside reset
`define JET_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define JET_ASSERT(label, clk, rst_n, prop, msg)
`define JET_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

// File: rtl/jet_pkg.sv
// shared types and constants for the julia escape-time block
// no dependencies
package jet_pkg;

  localparam int FracBits  = 28;
  localparam int ZW        = 32;
  localparam int CW        = 31;
  localparam int PW        = 2 * ZW;
  localparam int CountOutW = 9;
  localparam int IterLimit = 256;
  localparam int CountMax  = 511;

  // counter holds the limit itself and is never narrower than the output field
  localparam int CntW = ($clog2(IterLimit + 1) > CountOutW) ? $clog2(IterLimit + 1)
                                                              : CountOutW;

  localparam logic [PW-1:0] EscBound = PW'(4) << (2 * FracBits);

  localparam logic signed [CW-1:0] CRealReset = -31'sd216090542;
  localparam logic signed [CW-1:0] CImagReset = -31'sd54250806;

  // register indexes of the configuration port
  localparam logic CfgCReal = 1'b0;
  localparam logic CfgCImag = 1'b1;

  typedef enum logic [1:0] {
    SEL_RR = 2'd0,
    SEL_II = 2'd1,
    SEL_RI = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     busy;
    logic     load;
    mul_sel_e sel;
    logic     take_rr;
    logic     take_ii;
    logic     upd;
    logic     finish;
  } ctrl_t;

  typedef struct packed {
    logic escape;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/jet_mul.sv
// shared signed 32x32 multiplier with registered product
// depends on jet_pkg
module jet_mul (
  input  logic                            clk_i,
  input  jet_pkg::mul_sel_e               sel_i,
  input  logic signed [jet_pkg::ZW-1:0]   zr_i,
  input  logic signed [jet_pkg::ZW-1:0]   zi_i,
  output logic signed [jet_pkg::PW-1:0]   prod_o
);
  import jet_pkg::*;

  logic signed [ZW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_d, prod_q;

  always_comb begin
    case (sel_i)
      SEL_RR: begin
        op_a = zr_i;
        op_b = zr_i;
      end
      SEL_II: begin
        op_a = zi_i;
        op_b = zi_i;
      end
      SEL_RI: begin
        op_a = zr_i;
        op_b = zi_i;
      end
      default: begin
        op_a = zr_i;
        op_b = zr_i;
      end
    endcase
  end

  assign prod_d = PW'(op_a) * PW'(op_b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/jet_seq.sv
// sequencer: steps one point through the square, cross and update phases
// depends on jet_pkg
module jet_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  jet_pkg::stat_t            stat_i,
  output jet_pkg::ctrl_t            ctrl_o,
  output logic [jet_pkg::CntW-1:0]  count_o
);
  import jet_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL_RR = 6'b000010,
    ST_MUL_II = 6'b000100,
    ST_MUL_RI = 6'b001000,
    ST_UPD    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e            state_d, state_q;
  logic [CntW-1:0]   count_d, count_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ctrl_o  = '0;
    ctrl_o.sel  = SEL_RR;
    ctrl_o.busy = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          count_d     = '0;
          state_d     = ST_MUL_RR;
        end
      end
      ST_MUL_RR: begin
        ctrl_o.sel = SEL_RR;
        state_d    = ST_MUL_II;
      end
      ST_MUL_II: begin
        // product register holds zr*zr now
        ctrl_o.sel     = SEL_II;
        ctrl_o.take_rr = 1'b1;
        state_d        = ST_MUL_RI;
      end
      ST_MUL_RI: begin
        // product register holds zi*zi now
        ctrl_o.sel = SEL_RI;
        if (stat_i.escape) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.take_ii = 1'b1;
          state_d        = ST_UPD;
        end
      end
      ST_UPD: begin
        ctrl_o.upd = 1'b1;
        count_d    = count_q + CntW'(1);
        if (count_q == CntW'(IterLimit - 1)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL_RR;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// File: rtl/julia_escape_time.sv
// top level of the julia escape-time block: constant registers, point datapath,
// result register; uses jet_pkg, jet_seq, jet_mul and the assertion macros
`include "julia_escape_time_macros.svh"

// Takes a start point z (signed Q4.28) and runs z = z*z + c until |z|^2 reaches 4
// or IterLimit steps have run, then delivers the step count. One shared 32x32
// multiplier forms zr*zr, zi*zi and zr*zi in turn, so each step takes the three
// products and then the update. A point that escapes goes from its last escape
// test to ST_DONE, and one that never escapes goes there after its last update;
// ST_DONE moves the count into the result register once that register is free.
// The next point is taken in the cycle after the count has moved into the result
// register, also while that register is still stalled. c must be written by the
// user through the configuration port only while the block is idle; the block
// itself does not enforce this.
module julia_escape_time (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [jet_pkg::ZW-1:0]        z_real_i,
  input  logic signed [jet_pkg::ZW-1:0]        z_imag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [jet_pkg::CountOutW-1:0]        iteration_count_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [jet_pkg::CW-1:0]               cfg_data_i
);
  import jet_pkg::*;

  ctrl_t                  ctrl;
  stat_t                  stat;
  logic [CntW-1:0]        count;

  logic signed [CW-1:0]   c_real_q, c_imag_q;
  logic signed [ZW-1:0]   zr_d, zr_q, zi_d, zi_q;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   rr_q, ii_q;
  logic [PW-1:0]          mag;
  logic signed [PW-1:0]   diff, re_sh, im_sh;
  logic                   out_valid_d, out_valid_q;
  logic [CountOutW-1:0]   out_count_d, out_count_q;

  jet_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .count_o    (count)
  );

  jet_mul u_mul (
    .clk_i  (clk_i),
    .sel_i  (ctrl.sel),
    .zr_i   (zr_q),
    .zi_i   (zi_q),
    .prod_o (prod)
  );

  // constant registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q <= CRealReset;
      c_imag_q <= CImagReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgCReal: c_real_q <= cfg_data_i;
        CfgCImag: c_imag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // both squares are nonnegative, so the unsigned sum cannot wrap
  assign mag         = PW'(rr_q) + PW'(prod);
  assign stat.escape = (mag >= EscBound);

  // arithmetic shifts give the floor; the new point always fits 32 bits
  assign diff  = rr_q - ii_q;
  assign re_sh = diff >>> FracBits;
  assign im_sh = prod >>> (FracBits - 1);

  always_comb begin
    zr_d = zr_q;
    zi_d = zi_q;
    if (ctrl.load) begin
      zr_d = z_real_i;
      zi_d = z_imag_i;
    end else if (ctrl.upd) begin
      zr_d = re_sh[ZW-1:0] + ZW'(c_real_q);
      zi_d = im_sh[ZW-1:0] + ZW'(c_imag_q);
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q <= zr_d;
    zi_q <= zi_d;
    if (ctrl.take_rr) begin
      rr_q <= prod;
    end
    if (ctrl.take_ii) begin
      ii_q <= prod;
    end
  end

  // result register
  assign stat.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    if (ctrl.finish) begin
      out_valid_d = 1'b1;
      out_count_d = (count > CntW'(CountMax)) ? CountOutW'(CountMax)
                                               : count[CountOutW-1:0];
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign in_stall_o        = ctrl.busy;
  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = out_count_q;

  `JET_ASSERT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "block not busy after input transfer")
  `JET_ASSERT(a_count_in_range, clk_i, rst_ni, out_valid_o |-> (32'(iteration_count_o) <= 32'(IterLimit)), "iteration count above limit")
  `JET_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without a point in work")
  `JET_ASSERT_NEVER(a_no_drop, clk_i, rst_ni, ctrl.finish && out_valid_q && out_stall_i, "result register overwritten while stalled")

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// self-checking bench for julia_escape_time: directed and random start points under
// several julia constants, checked against a behavioral escape-count predictor
// depends on jet_pkg and the julia_escape_time rtl
module tb;
  import jet_pkg::*;

  typedef struct packed {
    logic signed [ZW-1:0] re;
    logic signed [ZW-1:0] im;
  } point_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  point_t               bus_point = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CountOutW-1:0] iteration_count;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_index = CfgCReal;
  logic [CW-1:0]        cfg_data  = '0;

  // bench copy of the julia constant
  logic signed [CW-1:0] c_re_model = CRealReset;
  logic signed [CW-1:0] c_im_model = CImagReset;

  point_t               pending_points[$];
  logic [CountOutW-1:0] expected_counts[$];
  logic [CountOutW-1:0] want_count;
  int                   send_wait   = 0;
  int                   points_taken = 0;
  int                   recv_wait   = 0;
  int                   counts_seen = 0;
  int                   mismatches  = 0;

  julia_escape_time u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .z_real_i          (bus_point.re),
    .z_imag_i          (bus_point.im),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .iteration_count_o (iteration_count),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // z = z*z + c in exact Q8.56 products, floored back to Q4.28
  function automatic logic [CountOutW-1:0] escape_steps(input logic signed [ZW-1:0] zr0,
                                                        input logic signed [ZW-1:0] zi0,
                                                        input logic signed [CW-1:0] cr,
                                                        input logic signed [CW-1:0] ci);
    longint    zr;
    longint    zi;
    longint    rr;
    longint    ii;
    longint    ri;
    logic [64:0] mag;
    bit        escaped;
    int        steps;
    zr = zr0;
    zi = zi0;
    steps = 0;
    escaped = 1'b0;
    while (!escaped && steps < IterLimit) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      mag = {1'b0, rr} + {1'b0, ii};
      if (mag >= (65'd4 << (2 * FracBits))) begin
        escaped = 1'b1;
      end else begin
        zr = ((rr - ii) >>> FracBits) + cr;
        zi = (ri >>> (FracBits - 1)) + ci;
        steps++;
      end
    end
    if (steps > CountMax) steps = CountMax;
    return steps[CountOutW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // sender: accepted points are predicted against the current constant
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_counts.push_back(escape_steps(bus_point.re, bus_point.im,
                                               c_re_model, c_im_model));
        points_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (pending_points.size() != 0) begin
          in_valid  <= 1'b1;
          bus_point <= pending_points.pop_front();
          // back-to-back stretches now and then
          send_wait = (points_taken % 150 < 25) ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each count transfer, then stalls for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("count %0d with no point pending", iteration_count));
        end else begin
          want_count = expected_counts.pop_front();
          if (iteration_count !== want_count)
            report_mismatch($sformatf("iteration_count %0d, expected %0d",
                                      iteration_count, want_count));
        end
        counts_seen++;
        // one long hold so the block backs up into its input
        if (counts_seen == 200) recv_wait = 3000;
        else if (counts_seen % 128 < 24) recv_wait = 0;
        else recv_wait = $urandom_range(0, 9);
      end
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_point(input logic signed [ZW-1:0] re, input logic signed [ZW-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    pending_points.push_back(p);
  endtask

  // mostly points in the -2..2 square, the rest anywhere in the field range
  task automatic add_random_points(input int n);
    int r;
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        add_point($urandom, $urandom);
      end else begin
        r = $urandom_range(0, 1 << 30);
        add_point(r - (1 << 29), $urandom_range(0, 1 << 30) - (1 << 29));
      end
    end
  endtask

  task automatic write_julia_const(input logic signed [CW-1:0] cr,
                                   input logic signed [CW-1:0] ci);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CfgCReal;
    cfg_data  <= cr;
    @(posedge clk_i);
    cfg_index <= CfgCImag;
    cfg_data  <= ci;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    c_re_model = cr;
    c_im_model = ci;
  endtask

  // sampled off the active edge so the sender's queue pop and valid agree
  task automatic wait_drained();
    while (pending_points.size() != 0 || in_valid || expected_counts.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset constant: field extremes, the escape bound and a few interior points
    add_point(32'sd0, 32'sd0);
    add_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    add_point(32'sh8000_0000, 32'sh8000_0000);
    add_point(32'sh8000_0000, 32'sd0);
    add_point(32'sd0, 32'sh8000_0000);
    add_point(32'sh7fff_ffff, 32'sh8000_0000);
    add_point(32'sh2000_0000, 32'sd0);
    add_point(32'sh1fff_ffff, 32'sd0);
    add_point(32'sd0, -32'sh2000_0000);
    add_point(32'sd0, -32'sh1fff_ffff);
    add_point(-32'sh1fff_ffff, 32'sd0);
    add_point(32'sh16a0_9e66, 32'sh16a0_9e66);
    add_point(32'sh16a0_9e67, 32'sh16a0_9e67);
    add_point(32'sd1, 32'sd1);
    add_point(-32'sd1, -32'sd1);
    add_point(32'sh0400_0000, -32'sh0800_0000);
    add_point(-32'sh0c00_0000, 32'sh0200_0000);
    add_random_points(180);
    wait_drained();

    write_julia_const(31'sd0, 31'sd0);
    add_point(32'sd0, 32'sd0);
    add_point(32'sh1000_0000, 32'sd0);
    add_random_points(100);
    wait_drained();

    write_julia_const(-31'sd536870912, 31'sd0);
    add_point(32'sd0, 32'sd0);
    add_random_points(100);
    wait_drained();

    write_julia_const(31'sd536870912, 31'sd536870912);
    add_random_points(100);
    wait_drained();

    write_julia_const(-31'sd536870912, -31'sd536870912);
    add_random_points(100);
    wait_drained();

    // constant beyond -2..2, full 31-bit span
    write_julia_const(31'sh4000_0000, 31'sh3fff_ffff);
    add_point(32'sd0, 32'sd0);
    add_random_points(60);
    wait_drained();

    write_julia_const($urandom_range(0, 1 << 30) - (1 << 29),
                      $urandom_range(0, 1 << 30) - (1 << 29));
    add_random_points(100);
    wait_drained();

    write_julia_const(CRealReset, CImagReset);
    add_random_points(140);
    wait_drained();

    repeat (4 * IterLimit + 16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/jet_pkg.sv
rtl/jet_mul.sv
rtl/jet_seq.sv
rtl/julia_escape_time.sv
test/tb.sv
